// ===== rtl/lpcs_pkg.sv =====
// Package for the latch-port command sequencer: request types, command
// codes, microcode word layout and the microprogram ROM. No dependencies.
`default_nettype none

package lpcs_pkg;

  // Command codes carried in the func field.
  localparam logic [2:0] FUNC_LATCH     = 3'd0;
  localparam logic [2:0] FUNC_DDS_RESET = 3'd1;
  localparam logic [2:0] FUNC_DDS_WRITE = 3'd2;
  localparam logic [2:0] FUNC_SHIFT     = 3'd3;
  localparam logic [2:0] FUNC_SET_DATA  = 3'd4;

  // Port addresses.
  localparam logic [1:0] PORT_DATA = 2'd1;
  localparam logic [1:0] PORT_CTRL = 2'd2;

  // Latch selects and data constants.
  localparam logic [7:0] SEL_FILTER   = 8'h02;
  localparam logic [7:0] SEL_DDS_DATA = 8'h04;
  localparam logic [7:0] SEL_DDS_ADDR = 8'h08;
  localparam logic [7:0] DDS_RST_LO   = 8'h40;
  localparam logic [7:0] DDS_RST_HI   = 8'hc0;

  // Bits of the shift-register working byte.
  localparam logic [7:0] WB_DATA_BIT  = 8'h01;
  localparam logic [7:0] WB_CLK_BIT   = 8'h02;
  localparam logic [7:0] WB_CLRN_BIT  = 8'h04;
  localparam logic [7:0] WB_LOAD_BIT  = 8'h20;

  // Microprogram counter width and entry points.
  localparam int unsigned UPC_W = 4;
  localparam logic [UPC_W-1:0] UPC_LATCH      = 4'd0;
  localparam logic [UPC_W-1:0] UPC_DDS_RESET  = 4'd1;
  localparam logic [UPC_W-1:0] UPC_DDS_WRITE  = 4'd4;
  localparam logic [UPC_W-1:0] UPC_SHIFT      = 4'd8;
  localparam logic [UPC_W-1:0] UPC_SHIFT_END  = 4'd10;
  localparam logic [UPC_W-1:0] UPC_SHIFT_ZERO = 4'd12;
  localparam logic [UPC_W-1:0] UPC_SET_DATA   = 4'd13;
  localparam logic [UPC_W-1:0] UPC_LAST       = 4'd13;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] select;
    logic [7:0] value;
  } cmd_req_t;

  typedef struct packed {
    logic [1:0] port_addr;
    logic [7:0] port_data;
    logic       last_write;
  } port_wr_t;

  // Where the data byte of a step comes from.
  typedef enum logic [2:0] {
    DS_VALUE, DS_K40, DS_KC0, DS_SEL_OR40, DS_SEL, DS_WORK
  } dsrc_e;

  // Where the latch select of a step comes from.
  typedef enum logic [1:0] {
    SS_CMD, SS_FILTER, SS_DDS_DATA, SS_DDS_ADDR
  } ssrc_e;

  // Operation on the shift working byte.
  typedef enum logic [2:0] {
    WB_NONE, WB_BIT, WB_CLK, WB_NOLOAD, WB_LOAD, WB_ZERO
  } wop_e;

  // Sequencing after the step.
  typedef enum logic [1:0] {
    NX_NEXT, NX_END, NX_LOOP, NX_JUMP
  } nx_e;

  typedef struct packed {
    logic             single;  // one data-port write instead of a latch
    dsrc_e            dsrc;
    ssrc_e            ssrc;
    wop_e             wop;
    nx_e              nx;
    logic [UPC_W-1:0] target;
  } uword_t;

  // Entry point of each command.
  function automatic logic [UPC_W-1:0] lpcs_entry(input logic [2:0] func,
                                                  input logic       val_zero);
    logic [UPC_W-1:0] e;
    e = UPC_LATCH;
    unique case (func)
      FUNC_LATCH:     e = UPC_LATCH;
      FUNC_DDS_RESET: e = UPC_DDS_RESET;
      FUNC_DDS_WRITE: e = UPC_DDS_WRITE;
      FUNC_SHIFT:     e = val_zero ? UPC_SHIFT_ZERO : UPC_SHIFT;
      FUNC_SET_DATA:  e = UPC_SET_DATA;
      default:        e = UPC_LATCH;
    endcase
    return e;
  endfunction

  // Microprogram ROM: one latch (or one data write) per word.
  function automatic uword_t lpcs_rom(input logic [UPC_W-1:0] a);
    uword_t w;
    w = '{1'b0, DS_VALUE, SS_CMD, WB_NONE, NX_END, UPC_LATCH};
    unique case (a)
      4'd0:  w = '{1'b0, DS_VALUE,    SS_CMD,      WB_NONE,   NX_END,  UPC_LATCH};
      4'd1:  w = '{1'b0, DS_K40,      SS_DDS_ADDR, WB_NONE,   NX_NEXT, UPC_LATCH};
      4'd2:  w = '{1'b0, DS_KC0,      SS_DDS_ADDR, WB_NONE,   NX_NEXT, UPC_LATCH};
      4'd3:  w = '{1'b0, DS_K40,      SS_DDS_ADDR, WB_NONE,   NX_END,  UPC_LATCH};
      4'd4:  w = '{1'b0, DS_VALUE,    SS_DDS_DATA, WB_NONE,   NX_NEXT, UPC_LATCH};
      4'd5:  w = '{1'b0, DS_SEL_OR40, SS_DDS_ADDR, WB_NONE,   NX_NEXT, UPC_LATCH};
      4'd6:  w = '{1'b0, DS_SEL,      SS_DDS_ADDR, WB_NONE,   NX_NEXT, UPC_LATCH};
      4'd7:  w = '{1'b0, DS_SEL_OR40, SS_DDS_ADDR, WB_NONE,   NX_END,  UPC_LATCH};
      4'd8:  w = '{1'b0, DS_WORK,     SS_FILTER,   WB_BIT,    NX_NEXT, UPC_LATCH};
      4'd9:  w = '{1'b0, DS_WORK,     SS_FILTER,   WB_CLK,    NX_LOOP, UPC_SHIFT};
      4'd10: w = '{1'b0, DS_WORK,     SS_FILTER,   WB_NOLOAD, NX_NEXT, UPC_LATCH};
      4'd11: w = '{1'b0, DS_WORK,     SS_FILTER,   WB_LOAD,   NX_END,  UPC_LATCH};
      4'd12: w = '{1'b0, DS_WORK,     SS_FILTER,   WB_ZERO,   NX_JUMP, UPC_SHIFT_END};
      4'd13: w = '{1'b1, DS_VALUE,    SS_CMD,      WB_NONE,   NX_END,  UPC_LATCH};
      default: w = '{1'b1, DS_VALUE,  SS_CMD,      WB_NONE,   NX_END,  UPC_LATCH};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/latch_port_command_sequencer_top.sv =====
// Top level of the latch-port command sequencer: microprogram sequencer,
// datapath and output register. Depends on lpcs_pkg.
`default_nettype none

// The block takes one command request and turns it into a run of port-write
// requests to a parallel-port emulation (address 1 data, address 2 control).
// The output carries one write per cycle while out_stall_i is low; a command
// has 1 write for set data, 3 for a latch, 9 for DDS reset, 12 for DDS
// write, 9 for a shift load of zero and 54 for a shift load of a nonzero
// value, and a stall on the output holds the run back. The pace is set
// by the single output register, which a microprogram step counter and a
// write-phase counter fill one write at a time. A new command is accepted
// in the cycle after the final write of the previous one has entered the
// output register, even while that write still waits to be taken. An
// unknown command code is accepted and produces no writes. The byte last
// latched into the filter latch (select 0x2) is remembered and seeds the
// shift-register bit patterns; reset clears it to zero.
module latch_port_command_sequencer_top (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire lpcs_pkg::cmd_req_t in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output lpcs_pkg::port_wr_t     out_req_o
);
  import lpcs_pkg::*;

  // Sequencer state.
  logic             busy_q, busy_d;
  logic [UPC_W-1:0] upc_q, upc_d;
  logic [1:0]       phase_q, phase_d;
  logic [2:0]       cnt_q, cnt_d;

  // Datapath registers.
  logic [7:0] sel_q, val_q, work_q, shadow_q;
  logic       out_valid_q;
  port_wr_t   out_q;

  uword_t     uw;
  logic [7:0] wb, data_byte, sel_byte;
  port_wr_t   wr;
  logic       step_done, advance, accept, is_end;

  assign accept     = in_valid_i && !busy_q;
  assign in_stall_o = busy_q;
  assign advance    = busy_q && (!out_valid_q || !out_stall_i);

  assign uw     = lpcs_rom(upc_q);
  assign is_end = (uw.nx == NX_END);

  // Working byte for this step; it replaces the stored one when the step ends.
  always_comb begin
    wb = work_q;
    unique case (uw.wop)
      WB_NONE:   wb = work_q;
      WB_BIT:    wb = (work_q & ~(WB_CLK_BIT | WB_DATA_BIT)) | {7'd0, val_q[cnt_q]};
      WB_CLK:    wb = work_q | WB_CLK_BIT;
      WB_NOLOAD: wb = work_q & ~(WB_CLK_BIT | WB_LOAD_BIT);
      WB_LOAD:   wb = work_q | WB_LOAD_BIT;
      WB_ZERO:   wb = work_q & ~WB_CLRN_BIT;
      default:   wb = work_q;
    endcase
  end

  always_comb begin
    data_byte = val_q;
    unique case (uw.dsrc)
      DS_VALUE:    data_byte = val_q;
      DS_K40:      data_byte = DDS_RST_LO;
      DS_KC0:      data_byte = DDS_RST_HI;
      DS_SEL_OR40: data_byte = sel_q | DDS_RST_LO;
      DS_SEL:      data_byte = sel_q;
      DS_WORK:     data_byte = wb;
      default:     data_byte = val_q;
    endcase
  end

  always_comb begin
    sel_byte = sel_q;
    unique case (uw.ssrc)
      SS_CMD:      sel_byte = sel_q;
      SS_FILTER:   sel_byte = SEL_FILTER;
      SS_DDS_DATA: sel_byte = SEL_DDS_DATA;
      SS_DDS_ADDR: sel_byte = SEL_DDS_ADDR;
      default:     sel_byte = sel_q;
    endcase
  end

  // A latch is data to the data port, the select to the control port, then
  // zero to the control port.
  always_comb begin
    step_done = uw.single || (phase_q == 2'd2);
    wr.last_write = step_done && is_end;
    if (uw.single || phase_q == 2'd0) begin
      wr.port_addr = PORT_DATA;
      wr.port_data = data_byte;
    end else if (phase_q == 2'd1) begin
      wr.port_addr = PORT_CTRL;
      wr.port_data = sel_byte;
    end else begin
      wr.port_addr = PORT_CTRL;
      wr.port_data = 8'd0;
    end
  end

  // Next-state logic of the sequencer.
  always_comb begin
    busy_d  = busy_q;
    upc_d   = upc_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    if (accept) begin
      busy_d  = (in_req_i.func <= FUNC_SET_DATA);
      upc_d   = lpcs_entry(in_req_i.func, in_req_i.value == 8'd0);
      phase_d = 2'd0;
      cnt_d   = 3'd7;
    end else if (advance) begin
      if (!step_done) begin
        phase_d = phase_q + 2'd1;
      end else begin
        phase_d = 2'd0;
        unique case (uw.nx)
          NX_NEXT: upc_d = upc_q + UPC_W'(1);
          NX_END:  busy_d = 1'b0;
          NX_LOOP: begin
            if (cnt_q != 3'd0) begin
              cnt_d = cnt_q - 3'd1;
              upc_d = uw.target;
            end else begin
              upc_d = upc_q + UPC_W'(1);
            end
          end
          NX_JUMP: upc_d = uw.target;
          default: busy_d = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      upc_q       <= UPC_LATCH;
      phase_q     <= 2'd0;
      cnt_q       <= 3'd0;
      out_valid_q <= 1'b0;
      shadow_q    <= 8'd0;
    end else begin
      busy_q  <= busy_d;
      upc_q   <= upc_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      // Any latch with the filter select records its byte.
      if (advance && step_done && !uw.single && sel_byte == SEL_FILTER) begin
        shadow_q <= data_byte;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sel_q  <= in_req_i.select;
      val_q  <= in_req_i.value;
      // Shift start: load set, address bits from the select, clear-not set,
      // clock low, the rest from the filter latch copy.
      work_q <= {shadow_q[7:6], 1'b1, in_req_i.select[4:3], 1'b1, 1'b0, shadow_q[0]};
    end else if (advance && step_done) begin
      work_q <= wb;
    end
    if (advance) begin
      out_q <= wr;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // The step counter never leaves the program.
  a_upc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (upc_q <= UPC_LAST))
    else $error("microprogram counter out of range");

  // A latch has exactly three phases.
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (phase_q != 2'd3))
    else $error("write phase out of range");

  // Loading the final write of a run frees the sequencer.
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && wr.last_write) |=> !busy_q)
    else $error("sequencer still busy after final write");

  // Only the data and control ports are ever addressed.
  a_port_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_req_o.port_addr == PORT_DATA ||
                     out_req_o.port_addr == PORT_CTRL))
    else $error("write to an unknown port");

endmodule

`default_nettype wire

// ===== bench/latch_port_command_sequencer_top_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for latch_port_command_sequencer_top: random and
// directed command requests in, port-write requests checked in order against
// a behavioral predictor. Depends on lpcs_pkg and the top-level RTL.

module latch_port_command_sequencer_top_test;
  import lpcs_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned RANDOM_CMDS   = 370;
  localparam int unsigned TAIL_CYCLES   = 60;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned REPORT_CAP    = 40;

  // Command codes the block does not know; they are accepted and dropped.
  localparam logic [2:0] FUNC_UNUSED_LO = FUNC_SET_DATA + 3'd1;
  localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;

  // Bit that marks the address write phases of a DDS write.
  localparam logic [7:0] DDS_WR_BIT = 8'h40;

  // A command request waiting to be offered, with the idle cycles to leave
  // before it and whether the sender first waits for all writes to drain.
  typedef struct {
    cmd_req_t    req;
    int unsigned gap;
    bit          drain;
  } queued_cmd_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  cmd_req_t in_req_i    = '0;
  logic     out_stall_i = 1'b0;
  logic     in_stall_o;
  logic     out_valid_o;
  port_wr_t out_req_o;

  queued_cmd_t cmds_pending[$];
  port_wr_t    writes_due[$];
  logic [7:0]  filter_shadow;
  int unsigned mismatch_count = 0;
  int unsigned writes_seen    = 0;
  int unsigned cycle_count    = 0;

  latch_port_command_sequencer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  always #4 clk_i = ~clk_i;

  // The run is bounded no matter what the block does.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < REPORT_CAP) begin
      $display("MISMATCH cycle %0d: %s", cycle_count, what);
    end
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------
  // Predictor. Each accepted command expands into the port writes it must
  // produce, appended to writes_due in order. The filter-latch shadow is
  // kept here and follows every latch with select 0x02.
  // ---------------------------------------------------------------------
  task automatic push_port_write(input logic [1:0] addr, input logic [7:0] data);
    port_wr_t w;
    w.port_addr  = addr;
    w.port_data  = data;
    w.last_write = 1'b0;
    writes_due.push_back(w);
  endtask

  // A latch: data byte on the data port, strobe the select, release it.
  task automatic push_latch(input logic [7:0] sel, input logic [7:0] data);
    if (sel == SEL_FILTER) begin
      filter_shadow = data;
    end
    push_port_write(PORT_DATA, data);
    push_port_write(PORT_CTRL, sel);
    push_port_write(PORT_CTRL, 8'h00);
  endtask

  task automatic expand_command(input cmd_req_t c);
    int unsigned first_new;
    logic [7:0]  wb;
    int          i;
    first_new = writes_due.size();
    case (c.func)
      FUNC_LATCH: begin
        push_latch(c.select, c.value);
      end
      FUNC_DDS_RESET: begin
        push_latch(SEL_DDS_ADDR, DDS_RST_LO);
        push_latch(SEL_DDS_ADDR, DDS_RST_HI);
        push_latch(SEL_DDS_ADDR, DDS_RST_LO);
      end
      FUNC_DDS_WRITE: begin
        push_latch(SEL_DDS_DATA, c.value);
        push_latch(SEL_DDS_ADDR, c.select | DDS_WR_BIT);
        push_latch(SEL_DDS_ADDR, c.select);
        push_latch(SEL_DDS_ADDR, c.select | DDS_WR_BIT);
      end
      FUNC_SHIFT: begin
        // Working byte: shadow with load and clear-not set, clock low, and
        // the register address taken from select bits 4 and 3.
        wb = filter_shadow | WB_LOAD_BIT | WB_CLRN_BIT;
        wb = wb & ~WB_CLK_BIT;
        wb[4:3] = c.select[4:3];
        if (c.value != 8'h00) begin
          for (i = 7; i >= 0; i--) begin
            wb[0] = c.value[i];
            push_latch(SEL_FILTER, wb);
            wb = wb | WB_CLK_BIT;
            push_latch(SEL_FILTER, wb);
            wb = wb & ~WB_CLK_BIT;
          end
        end else begin
          // A zero value just drives the register clear low, where it stays for the rest of the command.
          wb = wb & ~WB_CLRN_BIT;
          push_latch(SEL_FILTER, wb);
        end
        wb = wb & ~WB_LOAD_BIT;
        push_latch(SEL_FILTER, wb);
        wb = wb | WB_LOAD_BIT;
        push_latch(SEL_FILTER, wb);
      end
      FUNC_SET_DATA: begin
        push_port_write(PORT_DATA, c.value);
      end
      default: begin
        // Unknown commands produce nothing and leave the shadow alone.
      end
    endcase
    if (writes_due.size() > first_new) begin
      writes_due[$].last_write = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------
  task automatic queue_cmd(input logic [2:0] func, input logic [7:0] sel,
                           input logic [7:0] val, input int unsigned gap,
                           input bit drain);
    queued_cmd_t q;
    q.req.func   = func;
    q.req.select = sel;
    q.req.value  = val;
    q.gap        = gap;
    q.drain      = drain;
    cmds_pending.push_back(q);
  endtask

  // Mostly back to back or short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(80, 20);
  endfunction

  task automatic queue_random_cmd(input int unsigned gap, input bit drain);
    int unsigned r;
    logic [2:0]  func;
    logic [7:0]  sel;
    logic [7:0]  val;
    r   = $urandom_range(99);
    sel = 8'($urandom_range(255));
    val = 8'($urandom_range(255));
    if (r < 25) begin
      func = FUNC_LATCH;
      // Feed the filter latch often so the shift loads see fresh shadows.
      if ($urandom_range(99) < 35) sel = SEL_FILTER;
    end else if (r < 35) begin
      func = FUNC_DDS_RESET;
    end else if (r < 55) begin
      func = FUNC_DDS_WRITE;
    end else if (r < 80) begin
      func = FUNC_SHIFT;
      r = $urandom_range(99);
      if (r < 15) val = 8'h00;
      else if (r < 20) val = 8'hff;
    end else if (r < 94) begin
      func = FUNC_SET_DATA;
    end else begin
      func = 3'($urandom_range(FUNC_UNUSED_HI, FUNC_UNUSED_LO));
    end
    queue_cmd(func, sel, val, gap, drain);
  endtask

  // ---------------------------------------------------------------------
  // Sender. Offers the next queued request after its gap; valid stays high
  // and the payload unchanged until the block takes it. When a request is
  // taken and the next one has no gap or drain wait, valid simply stays high.
  // ---------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : sender
    int unsigned idle_count;
    logic        busy;
    queued_cmd_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i   <= '0;
      idle_count = 0;
    end else begin
      busy = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        expand_command(in_req_i);
        busy = 1'b0;
      end
      if (!busy) begin
        if (cmds_pending.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (idle_count < cmds_pending[0].gap) begin
          idle_count++;
          in_valid_i <= 1'b0;
        end else if (cmds_pending[0].drain && writes_due.size() != 0) begin
          // Pause until every write owed so far has come out.
          in_valid_i <= 1'b0;
        end else begin
          nxt = cmds_pending.pop_front();
          in_req_i   <= nxt.req;
          in_valid_i <= 1'b1;
          idle_count = 0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver. Stall comes in bursts whose density changes from stretch to
  // stretch, including stretches with no stall at all. Twice it holds off
  // for a long run of cycles so the block backs up into its input.
  // ---------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    int unsigned mode;
    int unsigned mode_left;
    int unsigned burst_left;
    int unsigned hold_left;
    int unsigned holds_done;
    logic        stall_next;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      mode       = 0;
      mode_left  = 0;
      burst_left = 0;
      hold_left  = 0;
      holds_done = 0;
    end else begin
      if (mode_left == 0) begin
        mode      = $urandom_range(2);
        mode_left = $urandom_range(200, 40);
      end else begin
        mode_left--;
      end
      if ((holds_done == 0 && writes_seen >= 150) ||
          (holds_done == 1 && writes_seen >= 3000)) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      stall_next = 1'b0;
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        stall_next = 1'b1;
      end else if ((mode == 1 && $urandom_range(99) < 15) ||
                   (mode == 2 && $urandom_range(99) < 40)) begin
        stall_next = 1'b1;
        if ($urandom_range(99) < 90) burst_left = $urandom_range(2);
        else burst_left = $urandom_range(40, 10);
      end
      out_stall_i <= stall_next;
    end
  end

  // ---------------------------------------------------------------------
  // Checker. Every taken port-write request is compared, field by field,
  // with the oldest write still owed.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : out_check
    port_wr_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      writes_seen++;
      if (writes_due.size() == 0) begin
        report_mismatch($sformatf("write addr %0d data %02h with nothing owed",
                                  out_req_o.port_addr, out_req_o.port_data));
      end else begin
        want = writes_due.pop_front();
        if (out_req_o.port_addr !== want.port_addr) begin
          report_mismatch($sformatf("port_addr %0d, wanted %0d",
                                    out_req_o.port_addr, want.port_addr));
        end
        if (out_req_o.port_data !== want.port_data) begin
          report_mismatch($sformatf("port_data %02h, wanted %02h",
                                    out_req_o.port_data, want.port_data));
        end
        if (out_req_o.last_write !== want.last_write) begin
          report_mismatch($sformatf("last_write %0b, wanted %0b",
                                    out_req_o.last_write, want.last_write));
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence: fill the request queue, release reset, wait for the
  // sender to run dry and every owed write to arrive, then judge.
  // ---------------------------------------------------------------------
  initial begin : sequence_ctl
    int unsigned n;
    bit          burst_window;
    filter_shadow = 8'h00;

    // Directed part: field extremes, every command, the filter-latch shadow
    // feeding the shift loads, a zero shift value, and unknown codes.
    queue_cmd(FUNC_SET_DATA,  8'h00, 8'h00, 0, 1'b0);
    queue_cmd(FUNC_SET_DATA,  8'hff, 8'hff, 0, 1'b0);
    queue_cmd(FUNC_LATCH,     8'h00, 8'h00, 0, 1'b0);
    queue_cmd(FUNC_LATCH,     8'hff, 8'ha5, 2, 1'b0);
    queue_cmd(FUNC_SHIFT,     8'h18, 8'h00, 0, 1'b0);
    queue_cmd(FUNC_LATCH,     SEL_FILTER, 8'hff, 0, 1'b0);
    queue_cmd(FUNC_SHIFT,     8'h00, 8'hff, 0, 1'b0);
    queue_cmd(FUNC_SHIFT,     8'he7, 8'h80, 0, 1'b0);
    queue_cmd(FUNC_LATCH,     SEL_FILTER, 8'h00, 0, 1'b1);
    queue_cmd(FUNC_SHIFT,     8'h08, 8'h01, 1, 1'b0);
    queue_cmd(FUNC_SHIFT,     8'h10, 8'h5a, 0, 1'b0);
    queue_cmd(FUNC_DDS_RESET, 8'h00, 8'h00, 0, 1'b0);
    queue_cmd(FUNC_DDS_RESET, 8'hff, 8'hff, 0, 1'b0);
    queue_cmd(FUNC_DDS_WRITE, 8'h00, 8'h00, 0, 1'b0);
    queue_cmd(FUNC_DDS_WRITE, 8'hff, 8'hff, 0, 1'b0);
    queue_cmd(FUNC_DDS_WRITE, 8'h3c, 8'h5a, 3, 1'b0);
    queue_cmd(FUNC_UNUSED_LO, 8'hff, 8'h00, 0, 1'b0);
    queue_cmd(FUNC_UNUSED_LO + 3'd1, 8'h00, 8'hff, 0, 1'b0);
    queue_cmd(FUNC_UNUSED_HI, 8'h55, 8'haa, 0, 1'b0);
    queue_cmd(FUNC_LATCH,     8'h01, 8'h7e, 0, 1'b0);
    queue_cmd(FUNC_SHIFT,     8'hff, 8'h00, 0, 1'b0);

    // Random part. One window of requests goes back to back, and the
    // sender drains the block now and then before going on.
    for (n = 0; n < RANDOM_CMDS; n++) begin
      burst_window = (n >= 120 && n < 180);
      queue_random_cmd(burst_window ? 0 : pick_gap(),
                       n == 0 || $urandom_range(99) < 3);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmds_pending.size() != 0 || in_valid_i) @(posedge clk_i);
    while (writes_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (writes_due.size() != 0) begin
      report_mismatch($sformatf("%0d writes never arrived", writes_due.size()));
    end
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lpcs_pkg.sv
rtl/latch_port_command_sequencer_top.sv
bench/latch_port_command_sequencer_top_test.sv
